// ===== sv/sudc_pkg.sv =====
package sudc_pkg;

   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int CURVE_ENTRIES_DEF = 64;

   // fixed point scale factors
   localparam int DB_PER_LOG2 = 394566;   // 20*log10(2), Q16
   localparam int LOG2_PER_DB = 2786635;  // log2(10)/20, Q24
   localparam int DB_FLOOR    = -30720;   // -120 dB, Q8.8
   localparam int DB_CEIL     = 32767;

   // register indexes
   localparam logic [2:0] CSR_ATTACK     = 3'd0;
   localparam logic [2:0] CSR_RELEASE    = 3'd1;
   localparam logic [2:0] CSR_DOWN_THR   = 3'd2;
   localparam logic [2:0] CSR_UP_THR     = 3'd3;
   localparam logic [2:0] CSR_DOWN_SLOPE = 3'd4;
   localparam logic [2:0] CSR_UP_SLOPE   = 3'd5;

   localparam logic [23:0]        ATTACK_RST     = 24'd16742300;
   localparam logic [23:0]        RELEASE_RST    = 24'd16773721;
   localparam logic signed [15:0] DOWN_THR_RST   = -16'sd5120;
   localparam logic signed [15:0] UP_THR_RST     = -16'sd10240;
   localparam logic [15:0]        DOWN_SLOPE_RST = 16'd58982;
   localparam logic [15:0]        UP_SLOPE_RST   = 16'd43691;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ENV_A,
      ST_ENV_B,
      ST_ENV_C,
      ST_NORM,
      ST_LOG_POS,
      ST_LOG_MUL,
      ST_LOG_SUM,
      ST_DB_MUL,
      ST_DB_RND,
      ST_GAIN_MUL,
      ST_GAIN_RND,
      ST_EXP_MUL,
      ST_EXP_RND,
      ST_EXP_MUL2,
      ST_EXP_SUM,
      ST_APP_MUL,
      ST_APP_SHIFT,
      ST_APP_SAT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      state_type  step;
      logic       ch;
      logic [2:0] norm_step;
      logic       load;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [23:0]        attack_coeff;
      logic [23:0]        release_coeff;
      logic signed [15:0] down_threshold_db;
      logic signed [15:0] up_threshold_db;
      logic [15:0]        down_slope;
      logic [15:0]        up_slope;
   } cfg_type;

   // log2 of m/2^30 for m in [2^30, 2^31), Q0.16, by repeated squaring
   function automatic logic [31:0] log2_frac(input logic [63:0] m);
      logic [63:0] x;
      logic [31:0] r;
      x = m;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= 64'h8000_0000) begin
            r = r | 32'd1;
            x = x >> 1;
         end
      end
      return r;
   endfunction

   // smallest m with log2_frac(m) >= floor(tnum / n)
   function automatic logic [31:0] exp_search(input logic [63:0] tnum, input int n);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'h4000_0000;
      hi = 64'h7FFF_FFFF;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if ((64'(log2_frac(mid)) + 64'd1) * 64'(n) > tnum)
            hi = mid;
         else
            lo = mid + 64'd1;
      end
      return lo[31:0];
   endfunction

   // divide by 2^sh, round half away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int sh);
      logic [63:0] half;
      logic [63:0] mag;
      half = 64'd1 << (sh - 1);
      if (v >= 0) begin
         mag = 64'(v);
         return $signed((mag + half) >> sh);
      end
      mag = 64'(-v);
      return -$signed((mag + half) >> sh);
   endfunction

endpackage

// ===== sv/sudc_ctrl.sv =====
module sudc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sudc_pkg::cmd_type  cmd
);

   sudc_pkg::state_type state_ff, state_in;
   logic                ch_ff, ch_in;
   logic [2:0]          norm_cnt_ff, norm_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_stall = (state_ff != sudc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == sudc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sudc_pkg::ST_IDLE;
         ch_ff        <= 1'b0;
         norm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         norm_cnt_ff  <= norm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      norm_cnt_in  = norm_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.step      = state_ff;
      cmd.ch        = ch_ff;
      cmd.norm_step = norm_cnt_ff;
      cmd.load      = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         sudc_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               ch_in    = 1'b0;
               state_in = sudc_pkg::ST_ENV_A;
            end
         end
         sudc_pkg::ST_ENV_A:     state_in = sudc_pkg::ST_ENV_B;
         sudc_pkg::ST_ENV_B:     state_in = sudc_pkg::ST_ENV_C;
         sudc_pkg::ST_ENV_C: begin
            norm_cnt_in = '0;
            state_in    = sudc_pkg::ST_NORM;
         end
         sudc_pkg::ST_NORM: begin
            norm_cnt_in = norm_cnt_ff + 3'd1;
            if (norm_cnt_ff == 3'd4)
               state_in = sudc_pkg::ST_LOG_POS;
         end
         sudc_pkg::ST_LOG_POS:   state_in = sudc_pkg::ST_LOG_MUL;
         sudc_pkg::ST_LOG_MUL:   state_in = sudc_pkg::ST_LOG_SUM;
         sudc_pkg::ST_LOG_SUM:   state_in = sudc_pkg::ST_DB_MUL;
         sudc_pkg::ST_DB_MUL:    state_in = sudc_pkg::ST_DB_RND;
         sudc_pkg::ST_DB_RND:    state_in = sudc_pkg::ST_GAIN_MUL;
         sudc_pkg::ST_GAIN_MUL:  state_in = sudc_pkg::ST_GAIN_RND;
         sudc_pkg::ST_GAIN_RND:  state_in = sudc_pkg::ST_EXP_MUL;
         sudc_pkg::ST_EXP_MUL:   state_in = sudc_pkg::ST_EXP_RND;
         sudc_pkg::ST_EXP_RND:   state_in = sudc_pkg::ST_EXP_MUL2;
         sudc_pkg::ST_EXP_MUL2:  state_in = sudc_pkg::ST_EXP_SUM;
         sudc_pkg::ST_EXP_SUM:   state_in = sudc_pkg::ST_APP_MUL;
         sudc_pkg::ST_APP_MUL:   state_in = sudc_pkg::ST_APP_SHIFT;
         sudc_pkg::ST_APP_SHIFT: state_in = sudc_pkg::ST_APP_SAT;
         sudc_pkg::ST_APP_SAT: begin
            if (ch_ff) begin
               state_in = sudc_pkg::ST_HOLD;
            end else begin
               ch_in    = 1'b1;
               state_in = sudc_pkg::ST_ENV_A;
            end
         end
         sudc_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sudc_pkg::ST_IDLE;
            end
         end
         default: state_in = sudc_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == sudc_pkg::ST_ENV_A && !ch_ff))
      else $error("request accepted without starting the left channel");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register loaded while a response is stalled");
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sudc_pkg::ST_NORM) |-> (norm_cnt_ff <= 3'd4))
      else $error("normalize step count out of range");
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sudc_pkg::ST_HOLD))
      else $error("response raised outside the hold state");
`endif

endmodule

// ===== sv/sudc_dp.sv =====
module sudc_dp #(
   parameter int SAMPLE_BITS   = sudc_pkg::SAMPLE_BITS_DEF,
   parameter int CURVE_ENTRIES = sudc_pkg::CURVE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sudc_pkg::cmd_type             cmd,
   input  sudc_pkg::cfg_type             cfg,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_right,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right
);

   localparam int IW  = $clog2(CURVE_ENTRIES + 1);
   localparam int PW  = 30 + IW;
   localparam int EPW = 16 + IW;

   // curve tables, built at elaboration
   logic [16:0] log_tab [0:CURVE_ENTRIES];
   logic [31:0] exp_tab [0:CURVE_ENTRIES];

   for (genvar k = 0; k <= CURVE_ENTRIES; k++) begin : g_tab
      if (k < CURVE_ENTRIES) begin : g_pt
         localparam logic [63:0] M0 = 64'h4000_0000 + ((64'(k) << 30) / CURVE_ENTRIES);
         localparam logic [16:0] LV = 17'(sudc_pkg::log2_frac(M0));
         localparam logic [31:0] EV = sudc_pkg::exp_search(64'(k) << 16, CURVE_ENTRIES);
         assign log_tab[k] = LV;
         assign exp_tab[k] = EV;
      end else begin : g_end
         assign log_tab[k] = 17'h1_0000;
         assign exp_tab[k] = 32'h8000_0000;
      end
   end

   logic [SAMPLE_BITS-1:0]  smp_ff [0:1];
   logic [31:0]             env_ff [0:1];
   logic [SAMPLE_BITS-1:0]  res_ff [0:1];
   logic [SAMPLE_BITS-1:0]  out_left_ff, out_right_ff;
   logic [55:0]             pa_ff;
   logic [56:0]             pb_ff;
   logic [31:0]             norm_ff;
   logic [4:0]              shc_ff;
   logic                    zero_ff;
   logic [IW-1:0]           lidx_ff;
   logic [29:0]             lrem_ff;
   logic [46:0]             lprod_ff;
   logic signed [22:0]      l2_ff;
   logic signed [43:0]      dbp_ff;
   logic signed [15:0]      db_ff;
   logic signed [33:0]      gp_ff;
   logic signed [15:0]      g_ff;
   logic signed [39:0]      ep_ff;
   logic signed [7:0]       ie_ff;
   logic [IW-1:0]           eidx_ff;
   logic [15:0]             erem_ff;
   logic [47:0]             eprod_ff;
   logic [31:0]             g2_ff;
   logic [63:0]             aprod_ff;
   logic [63:0]             r_ff;

   logic                    ch;
   logic [SAMPLE_BITS-1:0]  smp;
   logic                    neg;
   logic [SAMPLE_BITS-1:0]  mag;
   logic [31:0]             lvl;
   logic [31:0]             env_cur;
   logic [23:0]             coef;
   logic [24:0]             coef_c;
   logic [57:0]             env_sum;
   logic [31:0]             env_new;
   logic [4:0]              amt;
   logic [31:0]             norm_mask;
   logic [PW-1:0]           lpos;
   logic [IW-1:0]           lidx_nx;
   logic [16:0]             ldiff;
   logic signed [22:0]      l2_sum;
   logic signed [63:0]      dbr;
   logic signed [16:0]      gdiff;
   logic [15:0]             gslope;
   logic signed [63:0]      gr;
   logic signed [63:0]      er;
   logic [EPW-1:0]          epos;
   logic [IW-1:0]           eidx_nx;
   logic [31:0]             ediff;
   logic signed [7:0]       shw;
   logic [5:0]              sh;
   logic [64:0]             rsum;
   logic [63:0]             limit;
   logic [63:0]             rsat;

   assign ch      = cmd.ch;
   assign smp     = smp_ff[ch];
   assign neg     = smp[SAMPLE_BITS-1];
   assign mag     = neg ? (~smp + 1'b1) : smp;
   assign lvl     = 32'(mag) << (32 - SAMPLE_BITS);
   assign env_cur = env_ff[ch];
   assign coef    = (lvl > env_cur) ? cfg.attack_coeff : cfg.release_coeff;
   assign coef_c  = 25'h100_0000 - 25'(coef);

   assign env_sum = 58'(pa_ff) + 58'(pb_ff) + 58'h80_0000;
   assign env_new = env_sum[55:24];

   assign amt       = 5'(5'd16 >> cmd.norm_step);
   assign norm_mask = ~(32'hFFFF_FFFF >> amt);

   assign lpos    = PW'(norm_ff[30:1]) * PW'(CURVE_ENTRIES);
   assign lidx_nx = lidx_ff + 1'b1;
   assign ldiff   = log_tab[lidx_nx] - log_tab[lidx_ff];
   assign l2_sum  = $signed({6'b0, log_tab[lidx_ff]}) + $signed({6'b0, lprod_ff[46:30]})
                  - $signed({2'b0, shc_ff, 16'b0});

   assign dbr = sudc_pkg::rnd_shift(64'(dbp_ff), 24);

   // downward branch wins when both thresholds are crossed
   always_comb begin
      priority if (db_ff > cfg.down_threshold_db) begin
         gdiff  = 17'(cfg.down_threshold_db) - 17'(db_ff);
         gslope = cfg.down_slope;
      end else if (db_ff < cfg.up_threshold_db) begin
         gdiff  = 17'(cfg.up_threshold_db) - 17'(db_ff);
         gslope = cfg.up_slope;
      end else begin
         gdiff  = '0;
         gslope = '0;
      end
   end

   assign gr      = sudc_pkg::rnd_shift(64'(gp_ff), 16);
   assign er      = sudc_pkg::rnd_shift(64'(ep_ff), 16);
   assign epos    = EPW'(er[15:0]) * EPW'(CURVE_ENTRIES);
   assign eidx_nx = eidx_ff + 1'b1;
   assign ediff   = exp_tab[eidx_nx] - exp_tab[eidx_ff];

   assign shw   = 8'sd30 - ie_ff;
   assign sh    = shw[5:0];
   assign rsum  = 65'(aprod_ff) + (65'd1 << (sh - 6'd1));
   assign limit = (64'd1 << (SAMPLE_BITS - 1)) - (neg ? 64'd0 : 64'd1);
   assign rsat  = (r_ff > limit) ? limit : r_ff;

   // envelopes start from silence
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff[0] <= '0;
         env_ff[1] <= '0;
      end else if (cmd.step == sudc_pkg::ST_ENV_C) begin
         env_ff[ch] <= env_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff[0] <= req_sample_left;
         smp_ff[1] <= req_sample_right;
      end
      if (cmd.out_load) begin
         out_left_ff  <= res_ff[0];
         out_right_ff <= res_ff[1];
      end
      unique case (cmd.step)
         sudc_pkg::ST_ENV_A: pa_ff <= 56'(coef) * 56'(env_cur);
         sudc_pkg::ST_ENV_B: pb_ff <= 57'(coef_c) * 57'(lvl);
         sudc_pkg::ST_ENV_C: begin
            norm_ff    <= env_new;
            shc_ff     <= '0;
            zero_ff    <= (env_new == 32'd0);
         end
         sudc_pkg::ST_NORM: begin
            if ((norm_ff & norm_mask) == 32'd0) begin
               norm_ff <= norm_ff << amt;
               shc_ff  <= shc_ff + amt;
            end
         end
         sudc_pkg::ST_LOG_POS: begin
            lidx_ff <= lpos[PW-1:30];
            lrem_ff <= lpos[29:0];
         end
         sudc_pkg::ST_LOG_MUL: lprod_ff <= 47'(ldiff) * 47'(lrem_ff);
         sudc_pkg::ST_LOG_SUM: l2_ff <= l2_sum;
         sudc_pkg::ST_DB_MUL:  dbp_ff <= 44'(l2_ff) * 44'(sudc_pkg::DB_PER_LOG2);
         sudc_pkg::ST_DB_RND: begin
            priority if (zero_ff || dbr < sudc_pkg::DB_FLOOR)
               db_ff <= 16'(sudc_pkg::DB_FLOOR);
            else if (dbr > sudc_pkg::DB_CEIL)
               db_ff <= 16'(sudc_pkg::DB_CEIL);
            else
               db_ff <= dbr[15:0];
         end
         sudc_pkg::ST_GAIN_MUL: gp_ff <= 34'(gdiff) * $signed({18'b0, gslope});
         sudc_pkg::ST_GAIN_RND: begin
            priority if (gr < -64'sd32768)
               g_ff <= 16'h8000;
            else if (gr > 64'sd32767)
               g_ff <= 16'h7FFF;
            else
               g_ff <= gr[15:0];
         end
         sudc_pkg::ST_EXP_MUL: ep_ff <= 40'(g_ff) * 40'(sudc_pkg::LOG2_PER_DB);
         sudc_pkg::ST_EXP_RND: begin
            ie_ff   <= er[23:16];
            eidx_ff <= epos[EPW-1:16];
            erem_ff <= epos[15:0];
         end
         sudc_pkg::ST_EXP_MUL2:  eprod_ff <= 48'(ediff) * 48'(erem_ff);
         sudc_pkg::ST_EXP_SUM:   g2_ff <= exp_tab[eidx_ff] + eprod_ff[47:16];
         sudc_pkg::ST_APP_MUL:   aprod_ff <= 64'(mag) * 64'(g2_ff);
         sudc_pkg::ST_APP_SHIFT: r_ff <= 64'(rsum >> sh);
         sudc_pkg::ST_APP_SAT:
            res_ff[ch] <= neg ? SAMPLE_BITS'(~rsat + 64'd1) : SAMPLE_BITS'(rsat);
         default: ;
      endcase
   end

   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;

endmodule

// ===== sv/stereo_up_down_compressor_core.sv =====
// Stereo upward/downward compressor. Each request carries one left/right sample
// pair; each channel keeps its own peak envelope (attack or release smoothing),
// converts it to dBFS through a log2 curve table (floor -120 dB), derives a cut
// above the down threshold or a boost below the up threshold, turns that gain
// into a linear factor through a 2^x curve table and applies it with 24-bit
// saturation (SAMPLE_BITS in general). One shared datapath handles the left then
// the right channel, 22 controller steps each, plus one step to move the pair
// into the output register; that step waits while an earlier response is
// still stalled there. rsp_valid rises when the pair is loaded, and req_stall
// stays high from the accept until then. A finished response sits in its own
// output register, so the next request is accepted while it waits. Write the
// csr registers only while no request is in flight; csr_ready is always high
// and index 6 or 7 is ignored.
module stereo_up_down_compressor_core #(
   parameter int SAMPLE_BITS   = sudc_pkg::SAMPLE_BITS_DEF,
   parameter int CURVE_ENTRIES = sudc_pkg::CURVE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_right,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [23:0]                   csr_data
);

   sudc_pkg::cmd_type cmd;
   sudc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   // control registers, reset to their defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff      <= sudc_pkg::ATTACK_RST;
         cfg_ff.release_coeff     <= sudc_pkg::RELEASE_RST;
         cfg_ff.down_threshold_db <= sudc_pkg::DOWN_THR_RST;
         cfg_ff.up_threshold_db   <= sudc_pkg::UP_THR_RST;
         cfg_ff.down_slope        <= sudc_pkg::DOWN_SLOPE_RST;
         cfg_ff.up_slope          <= sudc_pkg::UP_SLOPE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            sudc_pkg::CSR_ATTACK:     cfg_ff.attack_coeff      <= csr_data;
            sudc_pkg::CSR_RELEASE:    cfg_ff.release_coeff     <= csr_data;
            sudc_pkg::CSR_DOWN_THR:   cfg_ff.down_threshold_db <= csr_data[15:0];
            sudc_pkg::CSR_UP_THR:     cfg_ff.up_threshold_db   <= csr_data[15:0];
            sudc_pkg::CSR_DOWN_SLOPE: cfg_ff.down_slope        <= csr_data[15:0];
            sudc_pkg::CSR_UP_SLOPE:   cfg_ff.up_slope          <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // step sequencer, left then right channel: one step per cycle unless stalled
   sudc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // envelope, level, gain and output arithmetic
   sudc_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .CURVE_ENTRIES (CURVE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right)
   );

endmodule
